@@ design/ckblit_pkg.sv @@
// ----------------------------------------------------------------------------
// ckblit_pkg: shared types and constants of the color-keyed sprite blitter
// Item structs, configuration register map and the classified-pixel record
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ckblit_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 9;   // bitmap width/height and position counters
    localparam int COORD_W    = 16;  // origin registers
    localparam int COLOR_W    = 16;
    localparam int SX_W       = 8;
    localparam int SY_W       = 7;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_BITMAP_WIDTH  = 3'd2,
        CFG_BITMAP_HEIGHT = 3'd3,
        CFG_KEY_COLOR     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [DIM_W-1:0]   bitmap_width;
        logic [DIM_W-1:0]   bitmap_height;
        logic [COLOR_W-1:0] key_color;
    } cfg_t;

    // Input item
    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               in_memory;
    } pixel_t;

    // Result item
    typedef struct packed {
        logic               pixel_valid;
        logic [SX_W-1:0]    screen_x;
        logic [SY_W-1:0]    screen_y;
        logic [COLOR_W-1:0] color;
        logic               run_first;
        logic               run_last;
        logic               blit_done;
    } result_t;

    // Pixel after classification by the front end
    typedef struct packed {
        logic               empty;     // zero-size bitmap
        logic               vis;       // drawn: on screen, in memory, not keyed
        logic               last_col;
        logic               last_row;
        logic [SX_W-1:0]    x;
        logic [SY_W-1:0]    y;
        logic [COLOR_W-1:0] color;
    } class_t;

endpackage

@@ design/ckblit_fifo.sv @@
// ----------------------------------------------------------------------------
// ckblit_fifo: small register FIFO
// Single write, single read, first-word fall-through; push is ignored when full.
// ----------------------------------------------------------------------------
module ckblit_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fifo occupancy beyond depth");

endmodule

@@ design/ckblit_front.sv @@
// ----------------------------------------------------------------------------
// ckblit_front: pixel position tracking and classification
// Walks the bitmap raster, maps each pixel to the screen and decides whether
// it is drawn; marks row and bitmap ends.
// ----------------------------------------------------------------------------
module ckblit_front #(
    parameter int DISPLAY_WIDTH  = 160,
    parameter int DISPLAY_HEIGHT = 128,
    parameter int MAX_BITMAP_DIM = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ckblit_pkg::cfg_t    cfg,
    input  logic                accept,
    input  ckblit_pkg::pixel_t  pixel,
    output ckblit_pkg::class_t  cls
);

    localparam int DW   = ckblit_pkg::DIM_W;
    localparam int MW   = $clog2(MAX_BITMAP_DIM + 1);
    localparam int CW   = (MW > DW + 1) ? MW : DW + 1;
    localparam int PW   = ckblit_pkg::COORD_W + 2;
    localparam logic [CW-1:0]        MAX_DIM = CW'(MAX_BITMAP_DIM);
    localparam logic signed [PW-1:0] DISP_W  = PW'(DISPLAY_WIDTH);
    localparam logic signed [PW-1:0] DISP_H  = PW'(DISPLAY_HEIGHT);

    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;

    logic [CW-1:0]        w_raw, h_raw, w_eff, h_eff;
    logic                 last_col, last_row, empty;
    logic signed [PW-1:0] sx, sy;
    logic                 on_screen;

    // oversize dimensions saturate
    assign w_raw = CW'(cfg.bitmap_width);
    assign h_raw = CW'(cfg.bitmap_height);
    assign w_eff = (w_raw > MAX_DIM) ? MAX_DIM : w_raw;
    assign h_eff = (h_raw > MAX_DIM) ? MAX_DIM : h_raw;

    assign empty    = (w_eff == '0) || (h_eff == '0);
    assign last_col = (CW'(col_reg) + 1'b1) >= w_eff;
    assign last_row = (CW'(row_reg) + 1'b1) >= h_eff;

    assign sx = $signed({{2{cfg.origin_x[ckblit_pkg::COORD_W-1]}}, cfg.origin_x})
              + $signed({{(PW-DW){1'b0}}, col_reg});
    assign sy = $signed({{2{cfg.origin_y[ckblit_pkg::COORD_W-1]}}, cfg.origin_y})
              + $signed({{(PW-DW){1'b0}}, row_reg});

    assign on_screen = !sx[PW-1] && (sx < DISP_W) && !sy[PW-1] && (sy < DISP_H);

    always_comb
    begin
        cls          = '0;
        cls.empty    = empty;
        cls.vis      = on_screen && pixel.in_memory && (pixel.pixel_color != cfg.key_color);
        cls.last_col = last_col;
        cls.last_row = last_row;
        cls.x        = sx[ckblit_pkg::SX_W-1:0];
        cls.y        = sy[ckblit_pkg::SY_W-1:0];
        cls.color    = pixel.pixel_color;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (empty)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ design/ckblit_back.sv @@
// ----------------------------------------------------------------------------
// ckblit_back: run assembly and result emission
// Holds the last drawn pixel back by one item to settle run_last; emits one result
// per cycle while the result queue has room; a two-result item pops after both.
// ----------------------------------------------------------------------------
module ckblit_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ckblit_pkg::class_t  item,
    input  logic                item_empty,
    output logic                item_pop,
    input  logic                out_full,
    output logic                out_push,
    output ckblit_pkg::result_t res
);

    logic                            held_valid_reg, held_valid_next;
    logic [ckblit_pkg::SX_W-1:0]     held_x_reg, held_x_next;
    logic [ckblit_pkg::SY_W-1:0]     held_y_reg, held_y_next;
    logic [ckblit_pkg::COLOR_W-1:0]  held_color_reg, held_color_next;
    logic                            held_first_reg, held_first_next;
    logic                            phase_reg, phase_next;   // second result pending

    logic go;
    logic blit_end;
    logic two_res;

    assign go       = !item_empty && !out_full;
    assign blit_end = item.last_col && item.last_row;
    assign two_res  = held_valid_reg && item.last_col && item.vis;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_color_next = held_color_reg;
        held_first_next = held_first_reg;
        phase_next      = phase_reg;
        item_pop        = 1'b0;
        out_push        = 1'b0;
        res             = '0;

        if (go)
        begin
            if (item.empty)
            begin
                out_push        = 1'b1;
                res.blit_done   = 1'b1;
                held_valid_next = 1'b0;
                phase_next      = 1'b0;
                item_pop        = 1'b1;
            end
            else if (phase_reg)
            begin
                // row end: flush the pixel captured from this item on its first pass
                out_push        = 1'b1;
                res.pixel_valid = 1'b1;
                res.screen_x    = held_x_reg;
                res.screen_y    = held_y_reg;
                res.color       = held_color_reg;
                res.run_first   = held_first_reg;
                res.run_last    = 1'b1;
                res.blit_done   = item.last_row;
                held_valid_next = 1'b0;
                phase_next      = 1'b0;
                item_pop        = 1'b1;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    out_push        = 1'b1;
                    res.pixel_valid = 1'b1;
                    res.screen_x    = held_x_reg;
                    res.screen_y    = held_y_reg;
                    res.color       = held_color_reg;
                    res.run_first   = held_first_reg;
                    res.run_last    = !item.vis;
                    res.blit_done   = blit_end && !two_res;
                end
                else if (item.vis && item.last_col)
                begin
                    // lone pixel at the row end
                    out_push        = 1'b1;
                    res.pixel_valid = 1'b1;
                    res.screen_x    = item.x;
                    res.screen_y    = item.y;
                    res.color       = item.color;
                    res.run_first   = 1'b1;
                    res.run_last    = 1'b1;
                    res.blit_done   = item.last_row;
                end
                else if (blit_end)
                begin
                    out_push      = 1'b1;
                    res.blit_done = 1'b1;
                end

                held_valid_next = item.vis && (!item.last_col || two_res);
                held_x_next     = item.x;
                held_y_next     = item.y;
                held_color_next = item.color;
                held_first_next = !held_valid_reg;
                phase_next      = two_res;
                item_pop        = !two_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_x_reg     <= held_x_next;
        held_y_reg     <= held_y_next;
        held_color_reg <= held_color_next;
        held_first_reg <= held_first_next;
    end

    a_phase_has_held: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> held_valid_reg)
        else $error("second-result phase without a held pixel");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full queue");

    a_phase_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && go) |=> !phase_reg)
        else $error("second-result phase did not retire");

    a_pop_once: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !phase_reg && two_res && !item.empty) |-> !item_pop)
        else $error("item popped before its second result");

endmodule

@@ design/color_key_sprite_blit_clipper.sv @@
// ----------------------------------------------------------------------------
// color_key_sprite_blit_clipper: color-keyed sprite blit with screen clipping
// Streams bitmap pixels in raster order, drops keyed, out-of-memory and
// off-screen pixels, and emits drawn pixels with run start/end flags and blit_done.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   -------------------------------------
//  pixel     push / full             pixel_t  (pixel_color, in_memory)
//  result    pop / empty             result_t (pixel_valid .. blit_done)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data (16 bit)
//
//  One pixel item per cycle while the input queue is not full. The front
//  end classifies in the cycle of acceptance; the back end retires one
//  queued item per cycle while the result queue has room, except an item
//  that closes a run at the row end while another pixel is held, which
//  stays at the queue head for its two results. Results are registered in the
//  result queue. Reset clears the raster position, the held pixel and both
//  queues; there is no clearing pass. Either side may stall freely: a 4-entry
//  queue sits between front and back, and a 4-entry queue buffers results.
//  Config is always ready; a write applies to pixels accepted after it.
// ----------------------------------------------------------------------------
module color_key_sprite_blit_clipper #(
    parameter int DISPLAY_WIDTH  = 160,
    parameter int DISPLAY_HEIGHT = 128,
    parameter int MAX_BITMAP_DIM = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // pixel input
    input  logic                                  push,
    output logic                                  full,
    input  ckblit_pkg::pixel_t                    pixel,
    // results
    output logic                                  empty,
    input  logic                                  pop,
    output ckblit_pkg::result_t                   result,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ckblit_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ckblit_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int Q_DEPTH = 4;
    localparam int CLS_W   = $bits(ckblit_pkg::class_t);
    localparam int RES_W   = $bits(ckblit_pkg::result_t);

    ckblit_pkg::cfg_t cfg_reg, cfg_next;

    ckblit_pkg::class_t  cls_in, cls_head;
    ckblit_pkg::result_t back_res;
    logic                accept;
    logic                mid_full, mid_empty, mid_pop;
    logic                out_full, out_push;
    logic [CLS_W-1:0]    cls_head_bits;
    logic [RES_W-1:0]    result_bits;

    // ---- configuration registers ----
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ckblit_pkg::CFG_ORIGIN_X:      cfg_next.origin_x = cfg_data;
                ckblit_pkg::CFG_ORIGIN_Y:      cfg_next.origin_y = cfg_data;
                ckblit_pkg::CFG_BITMAP_WIDTH:
                    cfg_next.bitmap_width  = cfg_data[ckblit_pkg::DIM_W-1:0];
                ckblit_pkg::CFG_BITMAP_HEIGHT:
                    cfg_next.bitmap_height = cfg_data[ckblit_pkg::DIM_W-1:0];
                ckblit_pkg::CFG_KEY_COLOR:     cfg_next.key_color = cfg_data;
                default:                       cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- front: raster walk and classification ----
    assign full   = mid_full;
    assign accept = push && !mid_full;

    ckblit_front #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .MAX_BITMAP_DIM (MAX_BITMAP_DIM)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .accept (accept),
        .pixel  (pixel),
        .cls    (cls_in)
    );

    // ---- decoupling queue ----
    ckblit_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (Q_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (cls_in),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (cls_head_bits),
        .empty   (mid_empty)
    );

    assign cls_head = ckblit_pkg::class_t'(cls_head_bits);

    // ---- back: hold-back and run flags ----
    ckblit_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (cls_head),
        .item_empty (mid_empty),
        .item_pop   (mid_pop),
        .out_full   (out_full),
        .out_push   (out_push),
        .res        (back_res)
    );

    // ---- result queue ----
    ckblit_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (back_res),
        .full    (out_full),
        .pop     (pop),
        .rd_data (result_bits),
        .empty   (empty)
    );

    assign result = ckblit_pkg::result_t'(result_bits);

endmodule

@@ tb/color_key_sprite_blit_clipper_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// color_key_sprite_blit_clipper_tb: self-checking bench for the sprite blitter
// Streams bitmap pixels through the push/full port under random stalls on both
// sides, and reprograms the blit registers between phases while the block is
// idle. A scoreboard class keeps its own copy of the raster position and the
// held-back pixel, predicts each drawn pixel or completion marker, and checks
// every popped result field by field in order.
// ----------------------------------------------------------------------------
module color_key_sprite_blit_clipper_tb;

    // Geometry handed to the block; the predictor clips against the same values
    localparam int SCREEN_W = 160;
    localparam int SCREEN_H = 128;
    localparam int DIM_MAX  = 256;

    // Register indexes past the map; writes there must leave every register alone
    localparam logic [ckblit_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [ckblit_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = 16;   // covers both 4-deep queues plus the back end
    localparam int WATCHDOG_LIMIT = 5000;

    logic                              clk;
    logic                              rst_n;
    logic                              push;
    logic                              full;
    ckblit_pkg::pixel_t                pixel;
    logic                              empty;
    logic                              pop;
    ckblit_pkg::result_t               result;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [ckblit_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ckblit_pkg::CFG_DATA_W-1:0] cfg_data;

    int idle_pct     = IDLE_PCT;
    int quiet_cycles = 0;
    int random_items = 0;

    color_key_sprite_blit_clipper #(
        .DISPLAY_WIDTH (SCREEN_W),
        .DISPLAY_HEIGHT(SCREEN_H),
        .MAX_BITMAP_DIM(DIM_MAX)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .pixel    (pixel),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Scoreboard: blit registers, raster position, held pixel, expected draws
    // ------------------------------------------------------------------------
    class blit_scoreboard;
        logic signed [ckblit_pkg::COORD_W-1:0] org_x;
        logic signed [ckblit_pkg::COORD_W-1:0] org_y;
        logic [ckblit_pkg::DIM_W-1:0]          bm_w;
        logic [ckblit_pkg::DIM_W-1:0]          bm_h;
        logic [ckblit_pkg::COLOR_W-1:0]        key;

        logic [ckblit_pkg::DIM_W-1:0]          row_pos;
        logic [ckblit_pkg::DIM_W-1:0]          col_pos;
        logic                                  held_valid;
        logic [ckblit_pkg::SX_W-1:0]           held_x;
        logic [ckblit_pkg::SY_W-1:0]           held_y;
        logic [ckblit_pkg::COLOR_W-1:0]        held_color;
        logic                                  held_first;

        ckblit_pkg::result_t                   pending_draws[$];
        int                                    errors;
        int                                    popped;

        function new();
            org_x = '0; org_y = '0; bm_w = '0; bm_h = '0; key = '0;
            row_pos = '0; col_pos = '0;
            held_valid = 1'b0; held_x = '0; held_y = '0;
            held_color = '0; held_first = 1'b0;
            errors = 0;
            popped = 0;
        endfunction

        function int pending();
            return pending_draws.size();
        endfunction

        function void write_reg(logic [ckblit_pkg::CFG_IDX_W-1:0] idx,
                                logic [ckblit_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                ckblit_pkg::CFG_ORIGIN_X:      org_x = data;
                ckblit_pkg::CFG_ORIGIN_Y:      org_y = data;
                ckblit_pkg::CFG_BITMAP_WIDTH:  bm_w  = data[ckblit_pkg::DIM_W-1:0];
                ckblit_pkg::CFG_BITMAP_HEIGHT: bm_h  = data[ckblit_pkg::DIM_W-1:0];
                ckblit_pkg::CFG_KEY_COLOR:     key   = data;
                default: ;   // spare index, dropped
            endcase
        endfunction

        function ckblit_pkg::result_t drawn(logic [ckblit_pkg::SX_W-1:0] x,
                                            logic [ckblit_pkg::SY_W-1:0] y,
                                            logic [ckblit_pkg::COLOR_W-1:0] c,
                                            logic first, logic last);
            ckblit_pkg::result_t r;
            r = '0;
            r.pixel_valid = 1'b1;
            r.screen_x    = x;
            r.screen_y    = y;
            r.color       = c;
            r.run_first   = first;
            r.run_last    = last;
            return r;
        endfunction

        // Advance the raster by one accepted pixel and queue what it releases
        function void note_pixel(ckblit_pkg::pixel_t p);
            ckblit_pkg::result_t step_out[$];
            ckblit_pkg::result_t marker;
            int      w;
            int      h;
            int      sx;
            int      sy;
            logic    row_end;
            logic    bitmap_end;
            logic    vis;
            logic    joined;

            w = (bm_w > DIM_MAX) ? DIM_MAX : int'(bm_w);
            h = (bm_h > DIM_MAX) ? DIM_MAX : int'(bm_h);
            marker = '0;
            marker.blit_done = 1'b1;

            // zero-size bitmap: every pixel finishes the blit on its own
            if (w == 0 || h == 0)
            begin
                pending_draws.push_back(marker);
                row_pos = '0;
                col_pos = '0;
                held_valid = 1'b0;
                return;
            end

            // past the end after a shrink counts as the end
            row_end    = (int'(col_pos) + 1 >= w);
            bitmap_end = (int'(row_pos) + 1 >= h);
            sx = int'(org_x) + int'(col_pos);
            sy = int'(org_y) + int'(row_pos);
            vis = (sx >= 0) && (sx < SCREEN_W) && (sy >= 0) && (sy < SCREEN_H)
                  && p.in_memory && (p.pixel_color != key);
            joined = 1'b0;

            if (held_valid)
            begin
                step_out.push_back(drawn(held_x, held_y, held_color, held_first, !vis));
                held_valid = 1'b0;
                joined = vis;
            end
            if (vis)
            begin
                held_valid = 1'b1;
                held_x     = 8'(sx);
                held_y     = 7'(sy);
                held_color = p.pixel_color;
                held_first = !joined;
            end
            // row end flushes the held pixel right away
            if (row_end && held_valid)
            begin
                step_out.push_back(drawn(held_x, held_y, held_color, held_first, 1'b1));
                held_valid = 1'b0;
            end

            if (row_end)
            begin
                col_pos = '0;
                if (bitmap_end)
                begin
                    row_pos = '0;
                    if (step_out.size() == 0)
                        step_out.push_back(marker);
                    else
                        step_out[step_out.size()-1].blit_done = 1'b1;
                end
                else
                begin
                    row_pos = row_pos + 1'b1;
                end
            end
            else
            begin
                col_pos = col_pos + 1'b1;
            end

            foreach (step_out[i])
                pending_draws.push_back(step_out[i]);
        endfunction

        task report(string msg);
            $display("[%0t] %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string field, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                 popped, field, got, want));
        endtask

        task check_result(ckblit_pkg::result_t got);
            ckblit_pkg::result_t want;
            if (pending_draws.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected: %p", popped, got));
            end
            else
            begin
                want = pending_draws.pop_front();
                compare_field("pixel_valid", 32'(got.pixel_valid), 32'(want.pixel_valid));
                compare_field("screen_x",    32'(got.screen_x),    32'(want.screen_x));
                compare_field("screen_y",    32'(got.screen_y),    32'(want.screen_y));
                compare_field("color",       32'(got.color),       32'(want.color));
                compare_field("run_first",   32'(got.run_first),   32'(want.run_first));
                compare_field("run_last",    32'(got.run_last),    32'(want.run_last));
                compare_field("blit_done",   32'(got.blit_done),   32'(want.blit_done));
            end
            popped++;
        endtask

        task final_check();
            if (pending_draws.size() != 0)
                report($sformatf("%0d expected results never arrived", pending_draws.size()));
        endtask
    endclass

    blit_scoreboard sb = new();

    // ------------------------------------------------------------------------
    // Clock, reset-time values
    // ------------------------------------------------------------------------
    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        push      = 1'b0;
        pixel     = '0;
        pop       = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
    end

    always #1 clk = ~clk;

    // Result side: pop stalls at the same rate as the pixel side idles
    always @(negedge clk)
        pop <= ($urandom_range(99) >= idle_pct);

    // Everything the block takes or gives is observed at the rising edge;
    // a pixel taken at the same edge as a register write still sees the old value
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_pixel(pixel);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (pop && !empty)
                sb.check_result(result);
        end
    end

    // Watchdog: a long run of edges with no handshake at all means a hang
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: all called and returning at a falling edge
    // ------------------------------------------------------------------------

    // Valid stays up from one pixel to the next; it only drops in an idle gap
    task automatic send_pixel(input logic [ckblit_pkg::COLOR_W-1:0] c, input logic in_mem);
        ckblit_pkg::pixel_t p;
        p.pixel_color = c;
        p.in_memory   = in_mem;
        while ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Same rule for cfg_valid: the caller lowers it after the last write
    task automatic write_reg(input logic [ckblit_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ckblit_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Idle the block before touching registers: all results out, then slack
    // for pixels that draw nothing but may still sit in the internal queue
    task automatic settle();
        push      <= 1'b0;
        cfg_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_blit(input logic [15:0] ox, input logic [15:0] oy,
                                input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] k);
        settle();
        write_reg(ckblit_pkg::CFG_ORIGIN_X, ox);
        write_reg(ckblit_pkg::CFG_ORIGIN_Y, oy);
        write_reg(ckblit_pkg::CFG_BITMAP_WIDTH, w);
        write_reg(ckblit_pkg::CFG_BITMAP_HEIGHT, h);
        write_reg(ckblit_pkg::CFG_KEY_COLOR, k);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_origin(int lo, int hi);
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(hi - lo) + lo);
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(11))
            0:       return 16'd0;
            1:       return 16'd256;
            2:       return 16'($urandom);          // high bits dropped, may saturate
            3:       return 16'($urandom_range(257, 511));
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [15:0] pick_key();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One random phase: reprogram some registers, then a burst of pixels.
    // Position carries over, so a phase boundary is often a mid-blit resize.
    task automatic random_phase();
        int   count;
        logic wrote;
        settle();
        wrote = 1'b0;
        if ($urandom_range(9) < 7)
        begin
            write_reg(ckblit_pkg::CFG_ORIGIN_X, pick_origin(-12, 170));
            wrote = 1'b1;
        end
        if ($urandom_range(9) < 7)
        begin
            write_reg(ckblit_pkg::CFG_ORIGIN_Y, pick_origin(-12, 138));
            wrote = 1'b1;
        end
        if ($urandom_range(9) < 6)
        begin
            write_reg(ckblit_pkg::CFG_BITMAP_WIDTH, pick_dim());
            wrote = 1'b1;
        end
        if ($urandom_range(9) < 6)
        begin
            write_reg(ckblit_pkg::CFG_BITMAP_HEIGHT, pick_dim());
            wrote = 1'b1;
        end
        if ($urandom_range(9) < 5)
        begin
            write_reg(ckblit_pkg::CFG_KEY_COLOR, pick_key());
            wrote = 1'b1;
        end
        if ($urandom_range(9) == 0)
        begin
            write_reg(ckblit_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      16'($urandom));
            wrote = 1'b1;
        end
        if (wrote)
            cfg_valid <= 1'b0;

        count = $urandom_range(1, 60);
        repeat (count)
        begin
            // a fair share of keyed pixels breaks rows into several runs
            if ($urandom_range(99) < 30)
                send_pixel(sb.key, $urandom_range(99) < 90);
            else
                send_pixel(16'($urandom), $urandom_range(99) < 90);
        end
        random_items += count;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Right and bottom edges: keyed, drawn, out of memory, off right edge;
        // second row is below the screen, so the blit ends with no pixel drawn
        write_reg(CFG_SPARE_FIRST, 16'hFFFF);
        program_blit(16'd157, 16'd127, 16'd4, 16'd2, 16'h1234);
        send_pixel(16'h1234, 1'b1);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hABCD, 1'b1);
        repeat (4) send_pixel(16'h0F0F, 1'b1);

        // Left edge: off-screen pixel, then a two-pixel run closed at row end;
        // second row ends the blit on a single drawn pixel
        program_blit(16'hFFFF, 16'd0, 16'd3, 16'd2, 16'hFFFF);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'h8000, 1'b1);
        send_pixel(16'h7FFF, 1'b1);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h5555, 1'b0);
        send_pixel(16'hAAAA, 1'b1);

        // Zero width, then zero height
        program_blit(16'd10, 16'd10, 16'd0, 16'd2, 16'h0000);
        send_pixel(16'h0000, 1'b1);
        program_blit(16'd10, 16'd10, 16'd5, 16'd0, 16'h0000);
        send_pixel(16'h4321, 1'b1);

        // Extreme origins, oversize width saturates; then shrink mid-row so the
        // column count is already past the new width
        program_blit(16'h8000, 16'h7FFF, 16'd511, 16'd2, 16'h0000);
        repeat (3) send_pixel(16'h0000, 1'b1);
        settle();
        write_reg(ckblit_pkg::CFG_BITMAP_WIDTH, 16'd2);
        cfg_valid <= 1'b0;
        repeat (3) send_pixel(16'hFFFF, 1'b1);

        // Random phases; a block of them in the middle runs with no stalls
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            idle_pct = (phase >= 20 && phase < 35) ? 0 : IDLE_PCT;
            random_phase();
            phase++;
        end
        idle_pct = IDLE_PCT;

        // Drain, then a few more edges to catch stray results
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.final_check();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ color_key_sprite_blit_clipper.f @@
design/ckblit_pkg.sv
design/ckblit_fifo.sv
design/ckblit_front.sv
design/ckblit_back.sv
design/color_key_sprite_blit_clipper.sv
tb/color_key_sprite_blit_clipper_tb.sv
